// ===== src/pps_pkg.sv =====
// Shared types, widths and constants of the point projection and splat block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package pps_pkg;

  // Field widths
  localparam int COEF_W     = 16;
  localparam int PT_W       = 32;
  localparam int CH_W       = 8;
  localparam int PROD_W     = 48;
  localparam int ACC_W      = 50;
  localparam int DIM_W      = 13;
  localparam int NUM_W      = 64;
  localparam int MAG_W      = 63;
  localparam int DEN_W      = 50;
  localparam int Q_W        = 13;
  localparam int CX_W       = Q_W + 1;
  localparam int POS_W      = 12;
  localparam int IDX_W      = 24;
  localparam int SW         = 16;
  localparam int ONE_SHIFT  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 72;

  // Parameter defaults
  localparam int MAX_DIM_DEF      = 4096;
  localparam int SPLAT_RADIUS_DEF = 2;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [CFG_DATA_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
  localparam logic [DIM_W-1:0]      WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]      HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  typedef logic [3:0][CFG_DATA_W-1:0] matrix_t;

  // One divider stage word, x and y side by side
  typedef struct packed {
    logic             skip;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] rem_x;
    logic [MAG_W-1:0] rem_y;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q_x;
    logic [Q_W-1:0]   q_y;
    color_t           color;
  } div_t;

  // Pick one signed Q4.12 coefficient from a packed matrix row
  function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_DATA_W-1:0] row,
                                                    input logic [1:0] col);
    coef = $signed(row[col*COEF_W +: COEF_W]);
  endfunction

endpackage

// ===== src/pps_project.sv =====
// Matrix transform stages: products, row sums, scaling by frame size.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_project (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [pps_pkg::PT_W-1:0]     point_x_i,
  input  logic signed [pps_pkg::PT_W-1:0]     point_y_i,
  input  logic signed [pps_pkg::PT_W-1:0]     point_z_i,
  input  pps_pkg::color_t                     color_i,
  input  pps_pkg::matrix_t                    matrix_i,
  input  logic [pps_pkg::DIM_W-1:0]           width_i,
  input  logic [pps_pkg::DIM_W-1:0]           height_i,
  output logic                                valid_o,
  output logic signed [pps_pkg::NUM_W-1:0]    num_x_o,
  output logic signed [pps_pkg::NUM_W-1:0]    num_y_o,
  output logic signed [pps_pkg::ACC_W-1:0]    den_o,
  output pps_pkg::color_t                     color_o
);

  localparam int PW = pps_pkg::PROD_W;
  localparam int AW = pps_pkg::ACC_W;

  logic signed [PW-1:0] prod_d [3][4];
  logic signed [PW-1:0] prod_q [3][4];
  logic signed [AW-1:0] acc_d  [3];
  logic signed [AW-1:0] acc_q  [3];
  logic                 v1_q, v2_q, v3_q;
  pps_pkg::color_t      c1_q, c2_q, c3_q;
  logic signed [pps_pkg::NUM_W-1:0] nx_q, ny_q;
  logic signed [AW-1:0] den_q;

  // Form products for rows x, y and w
  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam logic [1:0] MROW = (r == 2) ? 2'd3 : 2'(r);
    always_comb begin
      prod_d[r][0] = PW'(pps_pkg::coef(matrix_i[MROW], 2'd0)) * PW'(point_x_i);
      prod_d[r][1] = PW'(pps_pkg::coef(matrix_i[MROW], 2'd1)) * PW'(point_y_i);
      prod_d[r][2] = PW'(pps_pkg::coef(matrix_i[MROW], 2'd2)) * PW'(point_z_i);
      prod_d[r][3] = PW'(pps_pkg::coef(matrix_i[MROW], 2'd3)) <<< pps_pkg::ONE_SHIFT;
      acc_d[r]     = AW'(prod_q[r][0]) + AW'(prod_q[r][1])
                   + AW'(prod_q[r][2]) + AW'(prod_q[r][3]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      c1_q   <= color_i;
      acc_q  <= acc_d;
      c2_q   <= c1_q;
      nx_q   <= acc_q[0] * $signed({1'b0, width_i});
      ny_q   <= acc_q[1] * $signed({1'b0, height_i});
      den_q  <= acc_q[2];
      c3_q   <= c2_q;
    end
  end

  assign valid_o = v3_q;
  assign num_x_o = nx_q;
  assign num_y_o = ny_q;
  assign den_o   = den_q;
  assign color_o = c3_q;

endmodule

// ===== src/pps_divide.sv =====
// Pipelined restoring divider for x and y, one quotient bit per stage,
// with a skip flag for far points. Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_divide (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [pps_pkg::NUM_W-1:0]   num_x_i,
  input  logic signed [pps_pkg::NUM_W-1:0]   num_y_i,
  input  logic signed [pps_pkg::ACC_W-1:0]   den_i,
  input  pps_pkg::color_t                    color_i,
  output logic                               valid_o,
  output logic                               skip_o,
  output logic signed [pps_pkg::CX_W-1:0]    cx_o,
  output logic signed [pps_pkg::CX_W-1:0]    cy_o,
  output pps_pkg::color_t                    color_o
);

  localparam int MW = pps_pkg::MAG_W;
  localparam int DW = pps_pkg::DEN_W;
  localparam int QW = pps_pkg::Q_W;

  // Magnitude stage
  logic             v4_q;
  logic [MW-1:0]    mx_q, my_q;
  logic [DW-1:0]    md_q;
  logic             nx_q, ny_q, zero_q;
  pps_pkg::color_t  c4_q;

  logic [pps_pkg::NUM_W-1:0] ax_abs, ay_abs;
  logic [pps_pkg::ACC_W-1:0] d_abs;
  logic                      far;

  pps_pkg::div_t ds_d [QW+1];
  pps_pkg::div_t ds_q [QW+1];
  logic          dv_q [QW+1];

  always_comb begin
    ax_abs = num_x_i[pps_pkg::NUM_W-1] ? -num_x_i : num_x_i;
    ay_abs = num_y_i[pps_pkg::NUM_W-1] ? -num_y_i : num_y_i;
    d_abs  = den_i[pps_pkg::ACC_W-1] ? -den_i : den_i;
  end

  // Flag quotients too large to land near the frame
  always_comb begin
    far = (mx_q >= {md_q, {QW{1'b0}}}) || (my_q >= {md_q, {QW{1'b0}}});
    ds_d[0].skip  = zero_q || far;
    ds_d[0].neg_x = nx_q;
    ds_d[0].neg_y = ny_q;
    ds_d[0].rem_x = mx_q;
    ds_d[0].rem_y = my_q;
    ds_d[0].den   = md_q;
    ds_d[0].q_x   = '0;
    ds_d[0].q_y   = '0;
    ds_d[0].color = c4_q;
  end

  // One quotient bit per stage, most significant first
  for (genvar g = 1; g <= QW; g++) begin : g_div
    localparam int SH = QW - g;
    logic [MW-1:0] trial;
    always_comb begin
      trial    = MW'(ds_q[g-1].den) << SH;
      ds_d[g]  = ds_q[g-1];
      if (ds_q[g-1].rem_x >= trial) begin
        ds_d[g].rem_x   = ds_q[g-1].rem_x - trial;
        ds_d[g].q_x[SH] = 1'b1;
      end
      if (ds_q[g-1].rem_y >= trial) begin
        ds_d[g].rem_y   = ds_q[g-1].rem_y - trial;
        ds_d[g].q_y[SH] = 1'b1;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      for (int k = 0; k <= QW; k++) dv_q[k] <= 1'b0;
    end else if (en_i) begin
      v4_q    <= valid_i;
      dv_q[0] <= v4_q;
      for (int k = 1; k <= QW; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q   <= ax_abs[MW-1:0];
      my_q   <= ay_abs[MW-1:0];
      md_q   <= d_abs[DW-1:0];
      nx_q   <= num_x_i[pps_pkg::NUM_W-1] ^ den_i[pps_pkg::ACC_W-1];
      ny_q   <= num_y_i[pps_pkg::NUM_W-1] ^ den_i[pps_pkg::ACC_W-1];
      zero_q <= (den_i == '0);
      c4_q   <= color_i;
      for (int k = 0; k <= QW; k++) ds_q[k] <= ds_d[k];
    end
  end

  // Apply the sign, truncating toward zero
  assign valid_o = dv_q[QW];
  assign skip_o  = ds_q[QW].skip;
  assign cx_o    = ds_q[QW].neg_x ? -$signed({1'b0, ds_q[QW].q_x})
                                  :  $signed({1'b0, ds_q[QW].q_x});
  assign cy_o    = ds_q[QW].neg_y ? -$signed({1'b0, ds_q[QW].q_y})
                                  :  $signed({1'b0, ds_q[QW].q_y});
  assign color_o = ds_q[QW].color;

endmodule

// ===== src/pps_splat.sv =====
// Frame clipping of the splat square and the pixel sequencer with its
// output register. Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_splat #(
  parameter int SPLAT_RADIUS = pps_pkg::SPLAT_RADIUS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  output logic                                 adv_o,
  input  logic                                 valid_i,
  input  logic                                 skip_i,
  input  logic signed [pps_pkg::CX_W-1:0]      cx_i,
  input  logic signed [pps_pkg::CX_W-1:0]      cy_i,
  input  pps_pkg::color_t                      color_i,
  input  logic [pps_pkg::DIM_W-1:0]            width_i,
  input  logic [pps_pkg::DIM_W-1:0]            height_i,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [pps_pkg::POS_W-1:0]            col_o,
  output logic [pps_pkg::POS_W-1:0]            row_o,
  output logic [pps_pkg::IDX_W-1:0]            idx_o,
  output pps_pkg::color_t                      color_o,
  output logic                                 last_o
);

  localparam int SW    = pps_pkg::SW;
  localparam int PW    = pps_pkg::POS_W;
  localparam int OFF_W = $clog2(SPLAT_RADIUS + 1) + 1;
  localparam int MW    = pps_pkg::POS_W + pps_pkg::DIM_W;
  localparam logic signed [SW-1:0] RAD = SW'(SPLAT_RADIUS);

  logic signed [SW-1:0] hw_s, hh_s, cxs, cys;
  logic signed [SW-1:0] xlo, xhi, ylo, yhi;
  logic                 empty_d;

  // Clip register
  logic                    clip_v_q, clip_empty_q;
  logic signed [OFF_W-1:0] clip_ilo_q, clip_ihi_q, clip_jlo_q, clip_jhi_q;
  logic signed [SW-1:0]    clip_colb_q, clip_rowb_q;
  pps_pkg::color_t         clip_c_q;

  // Sequencer
  logic                    busy_q;
  logic signed [OFF_W-1:0] i_q, j_q, jlo_q, ihi_q, jhi_q;
  logic signed [SW-1:0]    colb_q, rowb_q;
  pps_pkg::color_t         cur_c_q;

  // Output register
  logic                    out_v_q, out_last_q;
  logic [PW-1:0]           out_col_q, out_row_q;
  logic [pps_pkg::IDX_W-1:0] out_idx_q;
  pps_pkg::color_t         out_c_q;

  logic          out_load, emit, last_now, gen_free, take;
  logic [PW-1:0] col_d, row_d;
  logic [MW-1:0] idx_full;

  // Intersect the splat square with the centered frame
  always_comb begin
    hw_s = SW'($signed({1'b0, width_i[pps_pkg::DIM_W-1:1]}));
    hh_s = SW'($signed({1'b0, height_i[pps_pkg::DIM_W-1:1]}));
    cxs  = SW'(cx_i);
    cys  = SW'(cy_i);
    xlo  = -hw_s - cxs;
    xhi  = hw_s - SW'(1) - cxs;
    ylo  = -hh_s - cys;
    yhi  = hh_s - SW'(1) - cys;
    if (xlo < -RAD) xlo = -RAD;
    if (xhi > RAD)  xhi = RAD;
    if (ylo < -RAD) ylo = -RAD;
    if (yhi > RAD)  yhi = RAD;
    empty_d = skip_i || (xlo > xhi) || (ylo > yhi);
  end

  // Handshake between clip register, sequencer and output register
  always_comb begin
    out_load = !out_v_q || m_ready_i;
    emit     = busy_q && out_load;
    last_now = (i_q == ihi_q) && (j_q == jhi_q);
    gen_free = !busy_q || (emit && last_now);
    take     = clip_v_q && (clip_empty_q || gen_free);
    adv_o    = !clip_v_q || take;
  end

  // Pixel coordinates of the current offset
  always_comb begin
    col_d    = PW'(colb_q + SW'(i_q));
    row_d    = PW'(rowb_q - SW'(j_q));
    idx_full = MW'(col_d) + MW'(row_d) * MW'(width_i);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_v_q <= 1'b0;
      busy_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (adv_o) clip_v_q <= valid_i;
      if (take && !clip_empty_q) busy_q <= 1'b1;
      else if (emit && last_now) busy_q <= 1'b0;
      if (out_load) out_v_q <= busy_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      clip_empty_q <= empty_d;
      clip_ilo_q   <= OFF_W'(xlo);
      clip_ihi_q   <= OFF_W'(xhi);
      clip_jlo_q   <= OFF_W'(ylo);
      clip_jhi_q   <= OFF_W'(yhi);
      clip_colb_q  <= cxs + hw_s;
      clip_rowb_q  <= hh_s - cys - SW'(1);
      clip_c_q     <= color_i;
    end
    // load a new point or step through the square, y innermost
    if (take && !clip_empty_q) begin
      i_q     <= clip_ilo_q;
      j_q     <= clip_jlo_q;
      jlo_q   <= clip_jlo_q;
      ihi_q   <= clip_ihi_q;
      jhi_q   <= clip_jhi_q;
      colb_q  <= clip_colb_q;
      rowb_q  <= clip_rowb_q;
      cur_c_q <= clip_c_q;
    end else if (emit && !last_now) begin
      if (j_q == jhi_q) begin
        j_q <= jlo_q;
        i_q <= i_q + OFF_W'(1);
      end else begin
        j_q <= j_q + OFF_W'(1);
      end
    end
    if (emit) begin
      out_col_q  <= col_d;
      out_row_q  <= row_d;
      out_idx_q  <= idx_full[pps_pkg::IDX_W-1:0];
      out_c_q    <= cur_c_q;
      out_last_q <= last_now;
    end
  end

  assign m_valid_o = out_v_q;
  assign col_o     = out_col_q;
  assign row_o     = out_row_q;
  assign idx_o     = out_idx_q;
  assign color_o   = out_c_q;
  assign last_o    = out_last_q;

endmodule

// ===== src/point_project_splat_top.sv =====
// Top level of the point projection and splat block: configuration
// registers and the pipeline. Depends on pps_pkg, pps_project, pps_divide, pps_splat.
`timescale 1ns / 1ps

// Usage
//   s_axis carries one point per word: position (Q16.16) and RGB color.
//   m_axis carries one splatted pixel per word; tlast marks the final pixel
//   of a point. A point off screen or with zero w yields no word.
//   cfg_* writes the four matrix rows and frame size; write only while idle.
// Throughput: a point enters every cycle while s_axis_tready is high; the output
//   runs one pixel a cycle while m_axis_tready is high. A point holds the sequencer
//   for its n visible pixels (up to 25 at radius 2); empty points pass without cost.
// The pipeline is 3 transform stages, 2 magnitude/range stages, 13 divider
//   stages (one quotient bit each), a clip stage, the sequencer and the
//   output register.
// Reset clears all valid bits and loads the identity matrix and 640x480.
// When m_axis stalls the output register holds; the pipeline freezes as a
//   whole and s_axis_tready drops once a point waits at the clip stage.
module point_project_splat_top #(
  parameter int MAX_DIM      = pps_pkg::MAX_DIM_DEF,
  parameter int SPLAT_RADIUS = pps_pkg::SPLAT_RADIUS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pps_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x, point_y, point_z, color_red, color_green, color_blue
  input  logic [pps_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_column, pixel_row, pixel_index, out_red, out_green, out_blue
  output logic [pps_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);

  pps_pkg::matrix_t            matrix_q;
  logic [pps_pkg::DIM_W-1:0]   width_q, height_q, wd, ht;
  logic                        adv;

  logic                                 p_valid;
  logic signed [pps_pkg::NUM_W-1:0]     p_nx, p_ny;
  logic signed [pps_pkg::ACC_W-1:0]     p_den;
  pps_pkg::color_t                      p_color, d_color, o_color, in_color;

  logic                                 d_valid, d_skip;
  logic signed [pps_pkg::CX_W-1:0]      d_cx, d_cy;

  logic [pps_pkg::POS_W-1:0]            o_col, o_row;
  logic [pps_pkg::IDX_W-1:0]            o_idx;

  // Take configuration words
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q[0] <= pps_pkg::ROW0_RST;
      matrix_q[1] <= pps_pkg::ROW1_RST;
      matrix_q[2] <= pps_pkg::ROW2_RST;
      matrix_q[3] <= pps_pkg::ROW3_RST;
      width_q     <= pps_pkg::WIDTH_RST;
      height_q    <= pps_pkg::HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pps_pkg::cfg_reg_e'(cfg_index_i))
        pps_pkg::REG_ROW0:   matrix_q[0] <= cfg_data_i;
        pps_pkg::REG_ROW1:   matrix_q[1] <= cfg_data_i;
        pps_pkg::REG_ROW2:   matrix_q[2] <= cfg_data_i;
        pps_pkg::REG_ROW3:   matrix_q[3] <= cfg_data_i;
        pps_pkg::REG_WIDTH:  width_q  <= cfg_data_i[pps_pkg::DIM_W-1:0];
        pps_pkg::REG_HEIGHT: height_q <= cfg_data_i[pps_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate frame size
  assign wd = (32'(width_q)  > MAX_DIM) ? pps_pkg::DIM_W'(MAX_DIM) : width_q;
  assign ht = (32'(height_q) > MAX_DIM) ? pps_pkg::DIM_W'(MAX_DIM) : height_q;

  assign s_axis_tready = adv;
  assign in_color = '{red:   s_axis_tdata[103:96],
                      green: s_axis_tdata[111:104],
                      blue:  s_axis_tdata[119:112]};

  pps_project u_project (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (s_axis_tvalid),
    .point_x_i ($signed(s_axis_tdata[31:0])),
    .point_y_i ($signed(s_axis_tdata[63:32])),
    .point_z_i ($signed(s_axis_tdata[95:64])),
    .color_i   (in_color),
    .matrix_i  (matrix_q),
    .width_i   (wd),
    .height_i  (ht),
    .valid_o   (p_valid),
    .num_x_o   (p_nx),
    .num_y_o   (p_ny),
    .den_o     (p_den),
    .color_o   (p_color)
  );

  pps_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (p_valid),
    .num_x_i (p_nx),
    .num_y_i (p_ny),
    .den_i   (p_den),
    .color_i (p_color),
    .valid_o (d_valid),
    .skip_o  (d_skip),
    .cx_o    (d_cx),
    .cy_o    (d_cy),
    .color_o (d_color)
  );

  pps_splat #(
    .SPLAT_RADIUS (SPLAT_RADIUS)
  ) u_splat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_o     (adv),
    .valid_i   (d_valid),
    .skip_i    (d_skip),
    .cx_i      (d_cx),
    .cy_i      (d_cy),
    .color_i   (d_color),
    .width_i   (wd),
    .height_i  (ht),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .col_o     (o_col),
    .row_o     (o_row),
    .idx_o     (o_idx),
    .color_o   (o_color),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {o_color.blue, o_color.green, o_color.red, o_idx, o_row, o_col};

endmodule

// ===== src/pps_checker.sv =====
// Port-level checks of point_project_splat_top and the bind that attaches them.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_checker #(
  parameter int MAX_DIM = pps_pkg::MAX_DIM_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [pps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [pps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [pps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic                               m_axis_tlast
);

  localparam int MW = pps_pkg::POS_W + pps_pkg::DIM_W;

  logic [pps_pkg::DIM_W-1:0] w_q, h_q, wd, ht;
  logic [MW-1:0]             idx_exp;

  // Track frame size from configuration words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= pps_pkg::WIDTH_RST;
      h_q <= pps_pkg::HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pps_pkg::REG_WIDTH)  w_q <= cfg_data_i[pps_pkg::DIM_W-1:0];
      if (cfg_index_i == pps_pkg::REG_HEIGHT) h_q <= cfg_data_i[pps_pkg::DIM_W-1:0];
    end
  end

  assign wd = (32'(w_q) > MAX_DIM) ? pps_pkg::DIM_W'(MAX_DIM) : w_q;
  assign ht = (32'(h_q) > MAX_DIM) ? pps_pkg::DIM_W'(MAX_DIM) : h_q;
  assign idx_exp = MW'(m_axis_tdata[11:0]) + MW'(m_axis_tdata[23:12]) * MW'(wd);

  // Stalled pixel word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("pixel word changed under stall");

  // Pixel lies inside the frame
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (MW'(m_axis_tdata[11:0]) < MW'(wd))
                   && (MW'(m_axis_tdata[23:12]) < MW'(ht)))
    else $error("pixel outside the frame");

  // Linear index agrees with column and row
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:24] == idx_exp[pps_pkg::IDX_W-1:0])
    else $error("pixel index mismatch");

endmodule

bind point_project_splat_top pps_checker #(.MAX_DIM(MAX_DIM)) u_pps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
